### hw/rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

  // task table size and derived widths
  localparam int MAX_TASKS = 8;
  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int PTR_W     = $clog2(MAX_TASKS + 1);

  // null link marker
  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_TASKS);

  // configuration widths
  localparam int SLICE_W   = 16;
  localparam int STEP_W    = 10;
  localparam int IDLE_W    = 3;
  localparam int REM_W     = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ID    = 2'd2;

  // configuration reset values
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd50;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd10;
  localparam logic [IDLE_W-1:0]  IDLE_RESET  = 3'd0;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_YIELD  = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_BLOCK  = 3'd3;
  localparam logic [2:0] REQ_LAUNCH = 3'd4;

  // list unit operations
  localparam logic [1:0] OP_UNLINK = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PUSH   = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] task_id;
  } req_t;

  typedef struct packed {
    logic [2:0] running_id;
    logic       switched;
    logic       error_code;
    logic [3:0] queue_count;
  } res_t;

  typedef struct packed {
    logic [SLICE_W-1:0] time_slice;
    logic [STEP_W-1:0]  tick_step;
    logic [IDLE_W-1:0]  idle_id;
  } cfg_t;

  typedef struct packed {
    logic            go;
    logic [1:0]      op;
    logic [ID_W-1:0] id;
  } list_cmd_t;

  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] len;
  } list_stat_t;

  function automatic logic is_task(input logic [PTR_W-1:0] ptr);
    return ptr < PTR_W'(MAX_TASKS);
  endfunction

endpackage

### hw/rtl/rrts_list.sv
`timescale 1ns / 1ps

// run queue storage with a small step sequencer: one pointer fix per array per cycle
module rrts_list (
  input  logic                   clk,
  input  logic                   rst,
  input  rrts_pkg::list_cmd_t    cmd,
  output rrts_pkg::list_stat_t   stat
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_RD   = 3'd1;
  localparam logic [2:0] L_UL   = 3'd2;
  localparam logic [2:0] L_L1   = 3'd3;
  localparam logic [2:0] L_L2   = 3'd4;

  logic [2:0]                    state;
  logic [1:0]                    op;
  logic [rrts_pkg::ID_W-1:0]     t;
  logic [rrts_pkg::PTR_W-1:0]    p;
  logic [rrts_pkg::PTR_W-1:0]    n;
  logic [rrts_pkg::PTR_W-1:0]    next_link [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::PTR_W-1:0]    prev_link [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::MAX_TASKS-1:0] queued;
  logic [rrts_pkg::PTR_W-1:0]    head;
  logic [rrts_pkg::PTR_W-1:0]    tail;
  logic [rrts_pkg::PTR_W-1:0]    len;
  logic                          done;
  logic [rrts_pkg::PTR_W-1:0]    t_ptr;

  assign t_ptr = rrts_pkg::PTR_W'(t);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      done   <= 1'b0;
      head   <= rrts_pkg::NIL;
      tail   <= rrts_pkg::NIL;
      len    <= '0;
      queued <= '0;
      for (int i = 0; i < rrts_pkg::MAX_TASKS; i++) begin
        next_link[i] <= rrts_pkg::NIL;
        prev_link[i] <= rrts_pkg::NIL;
      end
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (cmd.go) begin
            op    <= cmd.op;
            t     <= cmd.id;
            state <= L_RD;
          end
        end
        L_RD: begin
          p <= prev_link[t];
          n <= next_link[t];
          if (queued[t]) begin
            state <= L_UL;
          end else if (op == rrts_pkg::OP_UNLINK) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            state <= L_L1;
          end
        end
        L_UL: begin
          // splice the neighbours together
          if (rrts_pkg::is_task(p)) begin
            next_link[p[rrts_pkg::ID_W-1:0]] <= n;
          end else begin
            head <= n;
          end
          if (rrts_pkg::is_task(n)) begin
            prev_link[n[rrts_pkg::ID_W-1:0]] <= p;
          end else begin
            tail <= p;
          end
          queued[t] <= 1'b0;
          len       <= len - 1'b1;
          if (op == rrts_pkg::OP_UNLINK) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            state <= L_L1;
          end
        end
        L_L1: begin
          if (op == rrts_pkg::OP_PUSH) begin
            next_link[t] <= head;
            prev_link[t] <= rrts_pkg::NIL;
          end else begin
            prev_link[t] <= tail;
            next_link[t] <= rrts_pkg::NIL;
          end
          state <= L_L2;
        end
        L_L2: begin
          if (op == rrts_pkg::OP_PUSH) begin
            if (rrts_pkg::is_task(head)) begin
              prev_link[head[rrts_pkg::ID_W-1:0]] <= t_ptr;
            end else begin
              tail <= t_ptr;
            end
            head <= t_ptr;
          end else begin
            if (rrts_pkg::is_task(tail)) begin
              next_link[tail[rrts_pkg::ID_W-1:0]] <= t_ptr;
            end else begin
              head <= t_ptr;
            end
            tail <= t_ptr;
          end
          queued[t] <= 1'b1;
          len       <= len + 1'b1;
          done      <= 1'b1;
          state     <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.head = head;
  assign stat.tail = tail;
  assign stat.len  = len;

endmodule

### hw/rtl/rrts_ctrl.sv
`timescale 1ns / 1ps

// request sequencer: time accounting, rotation and launch decisions
module rrts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  rrts_pkg::req_t        req,
  input  rrts_pkg::cfg_t        cfg,
  output logic                  done,
  output rrts_pkg::res_t        result,
  output rrts_pkg::list_cmd_t   cmd,
  input  rrts_pkg::list_stat_t  stat
);

  localparam logic [2:0] C_IDLE   = 3'd0;
  localparam logic [2:0] C_EXEC   = 3'd1;
  localparam logic [2:0] C_SUB    = 3'd2;
  localparam logic [2:0] C_TAIL   = 3'd3;
  localparam logic [2:0] C_LAUNCH = 3'd4;
  localparam logic [2:0] C_PICK   = 3'd5;
  localparam logic [2:0] C_WAIT   = 3'd6;
  localparam logic [2:0] C_DONE   = 3'd7;

  logic [2:0]                      state;
  logic [2:0]                      ret_state;
  logic [2:0]                      req_type;
  logic [2:0]                      task_id;
  logic [rrts_pkg::ID_W-1:0]       cur;
  logic                            sw;
  logic                            err;
  logic signed [rrts_pkg::REM_W-1:0] remain [rrts_pkg::MAX_TASKS];
  logic signed [rrts_pkg::REM_W-1:0] diff;
  logic signed [rrts_pkg::REM_W-1:0] slice_ext;
  logic [rrts_pkg::ID_W-1:0]       idle;
  logic [rrts_pkg::PTR_W-1:0]      tid_ptr;

  assign idle      = rrts_pkg::ID_W'(cfg.idle_id);
  assign slice_ext = $signed({1'b0, cfg.time_slice});
  assign diff      = remain[cur] - $signed({7'd0, cfg.tick_step});
  assign tid_ptr   = rrts_pkg::PTR_W'(task_id);
  assign busy      = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      cur     <= '0;
      done    <= 1'b0;
      cmd.go  <= 1'b0;
      for (int i = 0; i < rrts_pkg::MAX_TASKS; i++) begin
        remain[i] <= rrts_pkg::REM_W'(rrts_pkg::SLICE_RESET);
      end
    end else begin
      done   <= 1'b0;
      cmd.go <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            req_type <= req.req_type;
            task_id  <= req.task_id;
            state    <= C_EXEC;
          end
        end
        C_EXEC: begin
          sw  <= 1'b0;
          err <= 1'b0;
          case (req_type)
            rrts_pkg::REQ_TICK: begin
              if (stat.len == '0) begin
                err   <= 1'b1;
                state <= C_DONE;
              end else if (cur == idle) begin
                state <= C_TAIL;
              end else begin
                state <= C_SUB;
              end
            end
            rrts_pkg::REQ_YIELD: begin
              if (cur != idle) begin
                remain[cur] <= slice_ext;
              end
              state <= C_TAIL;
            end
            rrts_pkg::REQ_INSERT: begin
              if (rrts_pkg::is_task(tid_ptr)) begin
                cmd.go    <= 1'b1;
                cmd.op    <= rrts_pkg::OP_PUSH;
                cmd.id    <= rrts_pkg::ID_W'(task_id);
                ret_state <= C_DONE;
                state     <= C_WAIT;
              end else begin
                state <= C_DONE;
              end
            end
            rrts_pkg::REQ_BLOCK: begin
              if (stat.len == '0) begin
                err   <= 1'b1;
                state <= C_DONE;
              end else begin
                cmd.go    <= 1'b1;
                cmd.op    <= rrts_pkg::OP_UNLINK;
                cmd.id    <= cur;
                ret_state <= C_DONE;
                state     <= C_WAIT;
              end
            end
            rrts_pkg::REQ_LAUNCH: begin
              if (stat.len == '0) begin
                err   <= 1'b1;
                state <= C_DONE;
              end else begin
                state <= C_LAUNCH;
              end
            end
            default: begin
              state <= C_DONE;
            end
          endcase
        end
        C_SUB: begin
          // quantum used up: refill and rotate; otherwise store the time left
          if (diff <= $signed(rrts_pkg::REM_W'(0))) begin
            remain[cur] <= slice_ext;
            state       <= C_TAIL;
          end else begin
            remain[cur] <= diff;
            state       <= C_DONE;
          end
        end
        C_TAIL: begin
          if (stat.tail == rrts_pkg::PTR_W'(cur)) begin
            state <= C_LAUNCH;
          end else begin
            cmd.go    <= 1'b1;
            cmd.op    <= rrts_pkg::OP_APPEND;
            cmd.id    <= cur;
            ret_state <= C_LAUNCH;
            state     <= C_WAIT;
          end
        end
        C_LAUNCH: begin
          if (!rrts_pkg::is_task(stat.head)) begin
            state <= C_DONE;
          end else if (stat.head == rrts_pkg::PTR_W'(idle) &&
                       stat.len >= rrts_pkg::PTR_W'(2)) begin
            // idle task at the head with others waiting: send it back
            cmd.go    <= 1'b1;
            cmd.op    <= rrts_pkg::OP_APPEND;
            cmd.id    <= idle;
            ret_state <= C_PICK;
            state     <= C_WAIT;
          end else begin
            state <= C_PICK;
          end
        end
        C_PICK: begin
          if (stat.head[rrts_pkg::ID_W-1:0] != cur) begin
            cur <= stat.head[rrts_pkg::ID_W-1:0];
            sw  <= 1'b1;
          end
          state <= C_DONE;
        end
        C_WAIT: begin
          if (stat.done) begin
            state <= ret_state;
          end
        end
        C_DONE: begin
          result.running_id  <= 3'(cur);
          result.switched    <= sw;
          result.error_code  <= err;
          result.queue_count <= 4'(stat.len);
          done               <= 1'b1;
          state              <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps

// channel   ports                       handshake
// -------   -------------------------   ------------------------------------------
// request   req (req_type, task_id)     taken when start is high and busy is low
// result    result (running_id, ...)    valid for one cycle while done is high
// config    wr_en, wr_index, wr_data    written on any edge with wr_en high
//
// from acceptance to the result, a refused or ignored request takes the shortest path, a tick
// with time left a longer one, and a tick that rotates the running task and then sends the
// idle task back past the head the longest; each list operation runs through the list unit,
// which fixes at most one link per array per cycle
// busy stays high from acceptance until the result strobe; results cannot be stalled
// synchronous reset empties the run queue and loads the default register values

module round_robin_task_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rrts_pkg::req_t                    req,
  output logic                              done,
  output rrts_pkg::res_t                    result,
  input  logic                              wr_en,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rrts_pkg::CFG_W-1:0]        wr_data
);

  rrts_pkg::cfg_t       cfg;
  rrts_pkg::list_cmd_t  cmd;
  rrts_pkg::list_stat_t stat;

  // configuration registers, index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_slice <= rrts_pkg::SLICE_RESET;
      cfg.tick_step  <= rrts_pkg::STEP_RESET;
      cfg.idle_id    <= rrts_pkg::IDLE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        rrts_pkg::CFG_TIME_SLICE: cfg.time_slice <= wr_data[rrts_pkg::SLICE_W-1:0];
        rrts_pkg::CFG_TICK_STEP:  cfg.tick_step  <= wr_data[rrts_pkg::STEP_W-1:0];
        rrts_pkg::CFG_IDLE_ID:    cfg.idle_id    <= wr_data[rrts_pkg::IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request sequencer: decides each step of a request
  rrts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .cfg    (cfg),
    .done   (done),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  // shared list unit: unlink, append at tail and push at head
  rrts_list u_list (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

### hw/rtl/rrts_checker.sv
`timescale 1ns / 1ps

module rrts_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input rrts_pkg::res_t                 result
);

  // an accepted request keeps the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy did not rise after request");

  // the result strobe only comes once the block is free again
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  // busy only ends with a result
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy fell without result");

  // a request that reports an error never switches
  assert property (@(posedge clk) disable iff (rst)
    (done && result.error_code) |-> !result.switched)
    else $error("switch reported with error");

  // queue never holds more than the task table
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.queue_count <= 4'(rrts_pkg::MAX_TASKS)))
    else $error("queue count out of range");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result)
);
